// ===== rtl/core/rrss_pkg.sv =====
// ============================================================================
// rrss_pkg
// Shared types and constants for the round-robin slice scheduler.
// ============================================================================
package rrss_pkg;

    localparam int TID_W   = 5;
    localparam int CMD_W   = 3;
    localparam int SLICE_W = 16;
    localparam int CNT_W   = 32;
    localparam int RCNT_W  = 6;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_YIELD  = 3'd3,
        CMD_START  = 3'd4,
        CMD_STOP   = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESCHED,
        ST_UNLINK_A,
        ST_UNLINK_B,
        ST_SWITCH,
        ST_APPEND_A,
        ST_APPEND_B,
        ST_TAKE,
        ST_RT_LOAD,
        ST_FINISH
    } state_t;

    // One link table entry
    typedef struct packed {
        logic [TID_W-1:0] prev;
        logic [TID_W-1:0] next;
    } link_ent_t;

    // Link table write request, with a strobe per field
    typedef struct packed {
        logic             we_next;
        logic             we_prev;
        logic [TID_W-1:0] id;
        link_ent_t        ent;
    } link_wr_t;

    // Runtime table write request
    typedef struct packed {
        logic             en;
        logic [TID_W-1:0] id;
        logic [CNT_W-1:0] data;
    } rt_wr_t;

endpackage

// ===== rtl/core/rrss_link_mem.sv =====
// ============================================================================
// rrss_link_mem
// Ready-queue link table: next and prev per thread, one write and one read
// port, registered read data.
// ============================================================================
module rrss_link_mem
    import rrss_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic                 clk,
    input  link_wr_t             wr,
    input  logic                 rd_en,
    input  logic [TID_W-1:0]     rd_id,
    output link_ent_t            rd_data
);

    localparam int IDX_W = $clog2(MAX_THREADS);

    logic [TID_W-1:0] next_mem [MAX_THREADS];
    logic [TID_W-1:0] prev_mem [MAX_THREADS];
    link_ent_t        rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_next)
        begin
            next_mem[IDX_W'(wr.id)] <= wr.ent.next;
        end
        if (wr.we_prev)
        begin
            prev_mem[IDX_W'(wr.id)] <= wr.ent.prev;
        end
        // hold read data between reads
        if (rd_en)
        begin
            rd_data_reg.next <= next_mem[IDX_W'(rd_id)];
            rd_data_reg.prev <= prev_mem[IDX_W'(rd_id)];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rrss_rt_mem.sv =====
// ============================================================================
// rrss_rt_mem
// Per-thread runtime table with a valid bit per entry; an entry never
// written reads as zero.
// ============================================================================
module rrss_rt_mem
    import rrss_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rt_wr_t               wr,
    input  logic                 rd_en,
    input  logic [TID_W-1:0]     rd_id,
    output logic [CNT_W-1:0]     rd_data
);

    localparam int IDX_W = $clog2(MAX_THREADS);

    logic [CNT_W-1:0]       rt_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] vld_reg;
    logic [CNT_W-1:0]       rd_raw_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rt_mem[IDX_W'(wr.id)] <= wr.data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= rt_mem[IDX_W'(rd_id)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[IDX_W'(wr.id)] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[IDX_W'(rd_id)];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// ===== rtl/core/round_robin_slice_scheduler_core.sv =====
// ============================================================================
// round_robin_slice_scheduler_core
// Round-robin time-slice thread scheduler with a linked-list ready queue.
// Sequencing: stop, ticks while stopped and ignored commands go straight from
//   execute to the status word; a tick that unlinks the head, requeues the old
//   thread and loads the new runtime does so before its status word.
// Flow: one command in work at a time; the next word is taken only once the
//   status word is in the output register, which can stall on m_tready.
// Reset: asynchronous; control state, queue flags and runtime valid bits
//   clear at once, no clearing pass; slice_length returns to 10.
// ============================================================================
module round_robin_slice_scheduler_core
    import rrss_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,

    // configuration: slice_length
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,

    // command words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // thread_id[4:0], thread_ready[5], current_runnable[6]
    input  logic [2:0]   s_tuser,   // cmd[2:0]

    // status words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // has_current[0], current_thread[5:1], switched[6],
                                    // none_ready[7], slice_left[23:8], queue_depth[29:24],
                                    // current_runtime[61:30], switch_total[93:62],
                                    // tick_total[125:94]
);

    localparam int QCNT_W = $clog2(MAX_THREADS + 1);
    localparam int IDX_W  = $clog2(MAX_THREADS);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                 state_reg,   state_next;
    logic [SLICE_W-1:0]     slen_reg,    slen_next;
    logic                   running_reg, running_next;
    logic                   cur_vld_reg, cur_vld_next;
    logic [TID_W-1:0]       cur_id_reg,  cur_id_next;
    logic [SLICE_W-1:0]     slice_reg,   slice_next;
    logic [TID_W-1:0]       head_reg,    head_next;
    logic [TID_W-1:0]       tail_reg,    tail_next;
    logic [QCNT_W-1:0]      qcnt_reg,    qcnt_next;
    logic [MAX_THREADS-1:0] inq_reg,     inq_next;
    logic [CNT_W-1:0]       sw_tot_reg,  sw_tot_next;
    logic [CNT_W-1:0]       tk_tot_reg,  tk_tot_next;
    logic [CNT_W-1:0]       cur_rt_reg,  cur_rt_next;

    // latched command word
    cmd_t                   cmd_reg,     cmd_next;
    logic [TID_W-1:0]       tid_reg,     tid_next;
    logic                   trdy_reg,    trdy_next;
    logic                   runn_reg,    runn_next;

    // sequencer scratch
    logic [TID_W-1:0]       tgt_reg,     tgt_next;     // thread being unlinked
    logic [TID_W-1:0]       app_reg,     app_next;     // thread being appended
    logic                   rs_reg,      rs_next;      // work belongs to a reschedule
    logic                   sw_reg,      sw_next;
    logic                   empty_reg,   empty_next;

    // output register
    logic                   ov_reg,      ov_next;
    logic [127:0]           od_reg,      od_next;

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    link_wr_t           link_wr;
    logic               link_rd_en;
    logic [TID_W-1:0]   link_rd_id;
    link_ent_t          link_rd;

    rt_wr_t             rt_wr;
    logic               rt_rd_en;
    logic [TID_W-1:0]   rt_rd_id;
    logic [CNT_W-1:0]   rt_rd;

    rrss_link_mem #(.MAX_THREADS(MAX_THREADS)) u_link_mem
    (
        .clk     (clk),
        .wr      (link_wr),
        .rd_en   (link_rd_en),
        .rd_id   (link_rd_id),
        .rd_data (link_rd)
    );

    rrss_rt_mem #(.MAX_THREADS(MAX_THREADS)) u_rt_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rt_wr),
        .rd_en   (rt_rd_en),
        .rd_id   (rt_rd_id),
        .rd_data (rt_rd)
    );

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = od_reg;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    logic               tid_ok;
    logic [SLICE_W-1:0] slice_dec;
    logic [CNT_W-1:0]   rt_inc;
    logic               out_free;

    always_comb
    begin
        state_next   = state_reg;
        slen_next    = slen_reg;
        running_next = running_reg;
        cur_vld_next = cur_vld_reg;
        cur_id_next  = cur_id_reg;
        slice_next   = slice_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        qcnt_next    = qcnt_reg;
        inq_next     = inq_reg;
        sw_tot_next  = sw_tot_reg;
        tk_tot_next  = tk_tot_reg;
        cur_rt_next  = cur_rt_reg;
        cmd_next     = cmd_reg;
        tid_next     = tid_reg;
        trdy_next    = trdy_reg;
        runn_next    = runn_reg;
        tgt_next     = tgt_reg;
        app_next     = app_reg;
        rs_next      = rs_reg;
        sw_next      = sw_reg;
        empty_next   = empty_reg;
        ov_next      = ov_reg;
        od_next      = od_reg;

        link_wr      = '0;
        link_rd_en   = 1'b0;
        link_rd_id   = '0;
        rt_wr        = '0;
        rt_rd_en     = 1'b0;
        rt_rd_id     = '0;

        tid_ok    = (32'(tid_reg) < MAX_THREADS);
        slice_dec = (slice_reg != '0) ? slice_reg - 1'b1 : slice_reg;
        rt_inc    = cur_rt_reg + 1'b1;
        out_free  = !ov_reg || m_tready;

        // drop the status word once taken
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_valid)
        begin
            slen_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    tid_next   = s_tdata[4:0];
                    trdy_next  = s_tdata[5];
                    runn_next  = s_tdata[6];
                    sw_next    = 1'b0;
                    empty_next = 1'b0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (running_reg)
                        begin
                            tk_tot_next = tk_tot_reg + 1'b1;
                            if (!cur_vld_reg)
                            begin
                                state_next = ST_RESCHED;
                            end
                            else
                            begin
                                // write-through of the cached runtime
                                cur_rt_next = rt_inc;
                                rt_wr.en    = 1'b1;
                                rt_wr.id    = cur_id_reg;
                                rt_wr.data  = rt_inc;
                                slice_next  = slice_dec;
                                if (slice_dec == '0)
                                begin
                                    state_next = ST_RESCHED;
                                end
                            end
                        end
                    end
                    CMD_ADD:
                    begin
                        if (trdy_reg && tid_ok && !inq_reg[IDX_W'(tid_reg)])
                        begin
                            app_next   = tid_reg;
                            rs_next    = 1'b0;
                            state_next = ST_APPEND_A;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (tid_ok && inq_reg[IDX_W'(tid_reg)])
                        begin
                            link_rd_en = 1'b1;
                            link_rd_id = tid_reg;
                            tgt_next   = tid_reg;
                            rs_next    = 1'b0;
                            state_next = ST_UNLINK_A;
                        end
                    end
                    CMD_YIELD:
                    begin
                        if (running_reg)
                        begin
                            if (cur_vld_reg)
                            begin
                                slice_next = '0;
                            end
                            state_next = ST_RESCHED;
                        end
                    end
                    CMD_START:
                    begin
                        running_next = 1'b1;
                        state_next   = ST_RESCHED;
                    end
                    CMD_STOP:
                    begin
                        running_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_RESCHED:
            begin
                if (qcnt_reg == '0)
                begin
                    empty_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // pull the head; its links arrive next cycle
                    link_rd_en = 1'b1;
                    link_rd_id = head_reg;
                    tgt_next   = head_reg;
                    rs_next    = 1'b1;
                    state_next = ST_UNLINK_A;
                end
            end

            ST_UNLINK_A:
            begin
                if (tgt_reg == head_reg)
                begin
                    head_next = link_rd.next;
                end
                else
                begin
                    link_wr.we_next  = 1'b1;
                    link_wr.id       = link_rd.prev;
                    link_wr.ent.next = link_rd.next;
                end
                state_next = ST_UNLINK_B;
            end

            ST_UNLINK_B:
            begin
                if (tgt_reg == tail_reg)
                begin
                    tail_next = link_rd.prev;
                end
                else
                begin
                    link_wr.we_prev  = 1'b1;
                    link_wr.id       = link_rd.next;
                    link_wr.ent.prev = link_rd.prev;
                end
                inq_next[IDX_W'(tgt_reg)] = 1'b0;
                qcnt_next  = qcnt_reg - 1'b1;
                state_next = rs_reg ? ST_SWITCH : ST_FINISH;
            end

            ST_SWITCH:
            begin
                if (cur_vld_reg && (cur_id_reg == tgt_reg))
                begin
                    // same thread picked again: reload only
                    slice_next = slen_reg;
                    state_next = ST_FINISH;
                end
                else if (cur_vld_reg && runn_reg && !inq_reg[IDX_W'(cur_id_reg)])
                begin
                    app_next   = cur_id_reg;
                    state_next = ST_APPEND_A;
                end
                else
                begin
                    state_next = ST_TAKE;
                end
            end

            ST_APPEND_A:
            begin
                link_wr.we_next  = 1'b1;
                link_wr.we_prev  = 1'b1;
                link_wr.id       = app_reg;
                link_wr.ent.prev = tail_reg;
                link_wr.ent.next = '0;
                if (qcnt_reg == '0)
                begin
                    head_next                 = app_reg;
                    tail_next                 = app_reg;
                    inq_next[IDX_W'(app_reg)] = 1'b1;
                    qcnt_next                 = qcnt_reg + 1'b1;
                    state_next                = rs_reg ? ST_TAKE : ST_FINISH;
                end
                else
                begin
                    state_next = ST_APPEND_B;
                end
            end

            ST_APPEND_B:
            begin
                link_wr.we_next           = 1'b1;
                link_wr.id                = tail_reg;
                link_wr.ent.next          = app_reg;
                tail_next                 = app_reg;
                inq_next[IDX_W'(app_reg)] = 1'b1;
                qcnt_next                 = qcnt_reg + 1'b1;
                state_next                = rs_reg ? ST_TAKE : ST_FINISH;
            end

            ST_TAKE:
            begin
                cur_vld_next = 1'b1;
                cur_id_next  = tgt_reg;
                slice_next   = slen_reg;
                sw_tot_next  = sw_tot_reg + 1'b1;
                sw_next      = 1'b1;
                rt_rd_en     = 1'b1;
                rt_rd_id     = tgt_reg;
                state_next   = ST_RT_LOAD;
            end

            ST_RT_LOAD:
            begin
                cur_rt_next = rt_rd;
                state_next  = ST_FINISH;
            end

            ST_FINISH:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = {2'b00,
                                  tk_tot_reg,
                                  sw_tot_reg,
                                  cur_vld_reg ? cur_rt_reg : {CNT_W{1'b0}},
                                  RCNT_W'(qcnt_reg),
                                  slice_reg,
                                  empty_reg,
                                  sw_reg,
                                  cur_vld_reg ? cur_id_reg : {TID_W{1'b0}},
                                  cur_vld_reg};
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slen_reg    <= SLICE_RESET;
            running_reg <= 1'b0;
            cur_vld_reg <= 1'b0;
            cur_id_reg  <= '0;
            slice_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            qcnt_reg    <= '0;
            inq_reg     <= '0;
            sw_tot_reg  <= '0;
            tk_tot_reg  <= '0;
            cur_rt_reg  <= '0;
            rs_reg      <= 1'b0;
            sw_reg      <= 1'b0;
            empty_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slen_reg    <= slen_next;
            running_reg <= running_next;
            cur_vld_reg <= cur_vld_next;
            cur_id_reg  <= cur_id_next;
            slice_reg   <= slice_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            qcnt_reg    <= qcnt_next;
            inq_reg     <= inq_next;
            sw_tot_reg  <= sw_tot_next;
            tk_tot_reg  <= tk_tot_next;
            cur_rt_reg  <= cur_rt_next;
            rs_reg      <= rs_next;
            sw_reg      <= sw_next;
            empty_reg   <= empty_next;
            ov_reg      <= ov_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tid_reg  <= tid_next;
        trdy_reg <= trdy_next;
        runn_reg <= runn_next;
        tgt_reg  <= tgt_next;
        app_reg  <= app_next;
        od_reg   <= od_next;
    end

endmodule
